FILE: src/cscr_pkg.sv
package cscr_pkg;

    localparam int PAGES   = 4;
    localparam int SLOTS   = 8;
    localparam int PAGE_W  = 2;
    localparam int SLOT_W  = 3;
    localparam int ADDR_W  = PAGE_W + SLOT_W;
    localparam int DEPTH   = PAGES * SLOTS;
    localparam int ENTRY_W = 8;
    localparam int COUNT_W = 3;

    localparam logic [3:0] STATUS_CC = 4'hB;

    localparam logic [6:0] CC_PAD_FIRST  = 7'd1;
    localparam logic [6:0] CC_PAD_LAST   = 7'd8;
    localparam logic [6:0] CC_ENC_FIRST  = 7'd11;
    localparam logic [6:0] CC_ENC_LAST   = 7'd18;
    localparam logic [6:0] CC_SW_FIRST   = 7'd19;
    localparam logic [6:0] CC_SW_LAST    = 7'd26;
    localparam logic [6:0] CC_DIAL       = 7'd34;
    localparam logic [6:0] CC_MODE_FIRST = 7'd35;
    localparam logic [6:0] CC_MODE_LAST  = 7'd38;
    localparam logic [6:0] CC_LEFT       = 7'd39;
    localparam logic [6:0] CC_RIGHT      = 7'd40;
    localparam logic [6:0] CC_BANK_FIRST = 7'd42;
    localparam logic [6:0] CC_BANK_LAST  = 7'd45;
    localparam logic [6:0] CC_DIV_HOLD   = 7'd57;
    localparam logic [6:0] CC_SHIFT      = 7'd58;

    localparam logic [6:0] VALUE_PRESSED = 7'd127;
    localparam logic [6:0] VALUE_MAX     = 7'd127;
    localparam logic [6:0] VALUE_RESET   = 7'd64;
    localparam logic [3:0] DIV_RESET     = 4'd1;

    typedef enum logic [3:0] {
        EV_PAD        = 4'd0,
        EV_ENCODER    = 4'd1,
        EV_DIV_PICK   = 4'd2,
        EV_SWITCH     = 4'd3,
        EV_DIAL       = 4'd4,
        EV_MODE_PAGE  = 4'd5,
        EV_LEFT       = 4'd6,
        EV_RIGHT      = 4'd7,
        EV_BANK       = 4'd8,
        EV_DIV_HELD   = 4'd9,
        EV_SHIFT_HELD = 4'd10
    } event_kind_t;

    typedef enum logic [1:0] {
        MOP_NONE   = 2'd0,
        MOP_ADJUST = 2'd1,
        MOP_TOGGLE = 2'd2
    } mem_op_t;

    typedef struct packed {
        event_kind_t         kind;
        mem_op_t             mop;
        logic [ADDR_W-1:0]   addr;
        logic [6:0]          delta;
        logic [3:0]          pad_number;
        logic [6:0]          velocity;
        logic [1:0]          pad_bank;
        logic [SLOT_W-1:0]   slot_index;
        logic [PAGE_W-1:0]   page_index;
        logic [3:0]          time_division;
        logic                flag;
    } item_t;

endpackage

FILE: src/cscr_ram.sv
module cscr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

FILE: src/cscr_decode.sv
module cscr_decode
    import cscr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         status_byte,
    input  logic [6:0]         data_one,
    input  logic [6:0]         data_two,
    input  logic               message_complete,
    input  logic               accept,
    input  logic               cfg_fire,
    input  logic [COUNT_W-1:0] cfg_count,
    output item_t              item,
    output logic               emit
);

    logic [PAGE_W-1:0]  page_reg, page_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [1:0]         bank_reg, bank_next;
    logic [3:0]         div_reg, div_next;
    logic               div_held_reg, div_held_next;
    logic               shift_reg, shift_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PAGE_W-1:0]  cfg_page;
    logic               is_cc;
    logic               pressed;
    logic [6:0]         offset;

    always_comb
    begin
        if (cfg_count == '0)
        begin
            count_next = COUNT_W'(1);
        end
        else if (cfg_count > COUNT_W'(PAGES))
        begin
            count_next = COUNT_W'(PAGES);
        end
        else
        begin
            count_next = cfg_count;
        end
        if ({1'b0, page_reg} >= count_next)
        begin
            cfg_page = PAGE_W'(count_next - COUNT_W'(1));
        end
        else
        begin
            cfg_page = page_reg;
        end
    end

    always_comb
    begin
        is_cc         = message_complete && (status_byte[7:4] == STATUS_CC);
        pressed       = (data_two == VALUE_PRESSED);
        offset        = '0;
        emit          = 1'b0;
        page_next     = page_reg;
        slot_next     = slot_reg;
        bank_next     = bank_reg;
        div_next      = div_reg;
        div_held_next = div_held_reg;
        shift_next    = shift_reg;
        item          = '0;
        item.kind     = EV_PAD;
        item.mop      = MOP_NONE;
        item.delta    = data_two;

        if (is_cc)
        begin
            if (data_one >= CC_PAD_FIRST && data_one <= CC_PAD_LAST)
            begin
                emit            = 1'b1;
                item.kind       = EV_PAD;
                item.pad_number = data_one[3:0];
                item.velocity   = data_two;
            end
            else if (data_one >= CC_ENC_FIRST && data_one <= CC_ENC_LAST)
            begin
                offset    = data_one - CC_ENC_FIRST;
                slot_next = offset[SLOT_W-1:0];
                emit      = 1'b1;
                item.kind = EV_ENCODER;
                item.mop  = MOP_ADJUST;
            end
            else if (data_one >= CC_SW_FIRST && data_one <= CC_SW_LAST)
            begin
                if (pressed)
                begin
                    offset    = data_one - CC_SW_FIRST;
                    slot_next = offset[SLOT_W-1:0];
                    emit      = 1'b1;
                    if (div_held_reg)
                    begin
                        div_next  = 4'({1'b0, offset[SLOT_W-1:0]}) + 4'd1;
                        item.kind = EV_DIV_PICK;
                    end
                    else
                    begin
                        item.kind = EV_SWITCH;
                        item.mop  = MOP_TOGGLE;
                    end
                end
            end
            else if (data_one == CC_DIAL)
            begin
                emit      = 1'b1;
                item.kind = EV_DIAL;
                item.mop  = MOP_ADJUST;
            end
            else if (data_one >= CC_MODE_FIRST && data_one <= CC_MODE_LAST && pressed)
            begin
                offset = data_one - CC_MODE_FIRST;
                if (COUNT_W'(offset[PAGE_W-1:0]) < count_reg)
                begin
                    page_next = offset[PAGE_W-1:0];
                    emit      = 1'b1;
                    item.kind = EV_MODE_PAGE;
                end
            end
            else if (data_one == CC_LEFT && pressed)
            begin
                if (page_reg == '0)
                begin
                    page_next = PAGE_W'(count_reg - COUNT_W'(1));
                end
                else
                begin
                    page_next = page_reg - PAGE_W'(1);
                end
                emit      = 1'b1;
                item.kind = EV_LEFT;
            end
            else if (data_one == CC_RIGHT && pressed)
            begin
                if (COUNT_W'(page_reg) + COUNT_W'(1) == count_reg)
                begin
                    page_next = '0;
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
                emit      = 1'b1;
                item.kind = EV_RIGHT;
            end
            else if (data_one >= CC_BANK_FIRST && data_one <= CC_BANK_LAST && pressed
                     && shift_reg)
            begin
                offset    = data_one - CC_BANK_FIRST;
                bank_next = offset[1:0];
                emit      = 1'b1;
                item.kind = EV_BANK;
            end
            else if (data_one == CC_DIV_HOLD)
            begin
                div_held_next = pressed;
                emit          = 1'b1;
                item.kind     = EV_DIV_HELD;
                item.flag     = pressed;
            end
            else if (data_one == CC_SHIFT)
            begin
                shift_next = pressed;
                emit       = 1'b1;
                item.kind  = EV_SHIFT_HELD;
                item.flag  = pressed;
            end
        end

        item.addr          = {page_next, slot_next};
        item.pad_bank      = bank_next;
        item.slot_index    = slot_next;
        item.page_index    = page_next;
        item.time_division = div_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg     <= '0;
            slot_reg     <= '0;
            bank_reg     <= '0;
            div_reg      <= DIV_RESET;
            div_held_reg <= 1'b0;
            shift_reg    <= 1'b0;
            count_reg    <= COUNT_W'(PAGES);
        end
        else
        begin
            if (accept)
            begin
                slot_reg     <= slot_next;
                bank_reg     <= bank_next;
                div_reg      <= div_next;
                div_held_reg <= div_held_next;
                shift_reg    <= shift_next;
            end
            if (cfg_fire)
            begin
                count_reg <= count_next;
                page_reg  <= cfg_page;
            end
            else if (accept)
            begin
                page_reg <= page_next;
            end
        end
    end

endmodule

FILE: src/cscr_update.sv
module cscr_update
    import cscr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  item_t               item,
    output logic                take_ready,
    input  logic [ENTRY_W-1:0]  ram_rdata,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic [ENTRY_W-1:0]  wr_data,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [3:0]          event_kind,
    output logic                render,
    output logic                pad_changed,
    output logic [3:0]          pad_number,
    output logic [6:0]          velocity,
    output logic                bank_changed,
    output logic [1:0]          pad_bank,
    output logic [2:0]          slot_index,
    output logic [6:0]          slot_value,
    output logic                flag_state,
    output logic [1:0]          page_index,
    output logic [3:0]          time_division
);

    logic                s1_valid_reg;
    item_t               s1_item_reg;
    logic                s1_init_reg;
    logic                byp_valid_reg;
    logic [ADDR_W-1:0]   byp_addr_reg;
    logic [ENTRY_W-1:0]  byp_data_reg;
    logic [DEPTH-1:0]    entry_valid_reg;
    logic                out_valid_reg;
    item_t               out_item_reg;
    logic [6:0]          out_value_reg;
    logic                out_flag_reg;

    logic                s1_adv;
    logic                byp_hit;
    logic [ENTRY_W-1:0]  cur_entry;
    logic [ENTRY_W-1:0]  new_entry;
    logic [7:0]          sum;
    logic [6:0]          adjusted;
    logic                new_flag;

    assign s1_adv     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign take_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        byp_hit = byp_valid_reg && (byp_addr_reg == s1_item_reg.addr);
        if (byp_hit)
        begin
            cur_entry = byp_data_reg;
        end
        else if (s1_init_reg)
        begin
            cur_entry = ram_rdata;
        end
        else
        begin
            cur_entry = {1'b0, VALUE_RESET};
        end

        sum = {1'b0, cur_entry[6:0]} + {1'b0, s1_item_reg.delta};
        if (s1_item_reg.delta == VALUE_PRESSED)
        begin
            adjusted = (cur_entry[6:0] == '0) ? '0 : cur_entry[6:0] - 7'd1;
        end
        else if (sum > {1'b0, VALUE_MAX})
        begin
            adjusted = VALUE_MAX;
        end
        else
        begin
            adjusted = sum[6:0];
        end

        case (s1_item_reg.mop)
            MOP_ADJUST: new_entry = {cur_entry[7], adjusted};
            MOP_TOGGLE: new_entry = {~cur_entry[7], cur_entry[6:0]};
            default:    new_entry = cur_entry;
        endcase

        new_flag = (s1_item_reg.mop == MOP_TOGGLE) ? new_entry[7] : s1_item_reg.flag;
    end

    assign wr_en   = s1_adv && (s1_item_reg.mop != MOP_NONE);
    assign wr_addr = s1_item_reg.addr;
    assign wr_data = new_entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            byp_valid_reg   <= 1'b0;
            entry_valid_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                s1_valid_reg  <= 1'b1;
                byp_valid_reg <= wr_en;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_item_reg  <= item;
            s1_init_reg  <= entry_valid_reg[item.addr];
            byp_addr_reg <= wr_addr;
            byp_data_reg <= wr_data;
        end
        if (s1_adv)
        begin
            out_item_reg  <= s1_item_reg;
            out_value_reg <= new_entry[6:0];
            out_flag_reg  <= new_flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = out_item_reg.kind;
    assign render        = (out_item_reg.kind != EV_DIV_HELD)
                           && (out_item_reg.kind != EV_SHIFT_HELD);
    assign pad_changed   = (out_item_reg.kind == EV_PAD);
    assign pad_number    = out_item_reg.pad_number;
    assign velocity      = out_item_reg.velocity;
    assign bank_changed  = (out_item_reg.kind == EV_BANK);
    assign pad_bank      = out_item_reg.pad_bank;
    assign slot_index    = out_item_reg.slot_index;
    assign slot_value    = out_value_reg;
    assign flag_state    = out_flag_reg;
    assign page_index    = out_item_reg.page_index;
    assign time_division = out_item_reg.time_division;

    a_write_marks_entry: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> entry_valid_reg[$past(wr_addr)])
        else $error("Written entry was not marked valid.");

    a_load_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!s1_valid_reg || s1_adv))
        else $error("Item loaded over an occupied read stage.");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("Advanced item did not reach the output register.");

endmodule

FILE: src/control_surface_cc_reducer_core.sv
// Reduces three-byte MIDI control-change messages from a control surface to at most one
// event result each. One message is accepted per clock cycle, and the output register
// lets the next message be taken while a result waits. Per-page slot values and switch
// flags sit in one 32-entry memory with a registered read; each message with a result
// reads its entry on acceptance, and an adjust or toggle writes it back as its result
// moves into the output register, with a bypass covering a read of the entry being
// written in the same cycle. The input stalls only while a result waits on the output
// and the next message already holds the read stage. Valid bits make the memory read
// as its reset contents after reset, so no clearing pass is needed. The page count
// register may be written only while the block is idle.
module control_surface_cc_reducer_core
    import cscr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         status_byte,
    input  logic [6:0]         data_one,
    input  logic [6:0]         data_two,
    input  logic               message_complete,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] page_count,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         event_kind,
    output logic               render,
    output logic               pad_changed,
    output logic [3:0]         pad_number,
    output logic [6:0]         velocity,
    output logic               bank_changed,
    output logic [1:0]         pad_bank,
    output logic [2:0]         slot_index,
    output logic [6:0]         slot_value,
    output logic               flag_state,
    output logic [1:0]         page_index,
    output logic [3:0]         time_division
);

    item_t              item;
    logic               emit;
    logic               accept;
    logic               load;
    logic               take_ready;
    logic [ENTRY_W-1:0] ram_rdata;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = take_ready;
    assign accept    = in_valid && take_ready;
    assign load      = accept && emit;

    cscr_decode u_decode (
        .clk              (clk),
        .rst_n            (rst_n),
        .status_byte      (status_byte),
        .data_one         (data_one),
        .data_two         (data_two),
        .message_complete (message_complete),
        .accept           (accept),
        .cfg_fire         (cfg_valid && cfg_ready),
        .cfg_count        (page_count),
        .item             (item),
        .emit             (emit)
    );

    cscr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (load),
        .rd_addr (item.addr),
        .rd_data (ram_rdata)
    );

    cscr_update u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .item          (item),
        .take_ready    (take_ready),
        .ram_rdata     (ram_rdata),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .render        (render),
        .pad_changed   (pad_changed),
        .pad_number    (pad_number),
        .velocity      (velocity),
        .bank_changed  (bank_changed),
        .pad_bank      (pad_bank),
        .slot_index    (slot_index),
        .slot_value    (slot_value),
        .flag_state    (flag_state),
        .page_index    (page_index),
        .time_division (time_division)
    );

endmodule

FILE: verif/tb_control_surface_cc_reducer_core.sv
`timescale 1ns / 100ps

module tb_control_surface_cc_reducer_core;
    import cscr_pkg::*;

    localparam logic [3:0] STATUS_POLY    = 4'hA;
    localparam logic [3:0] STATUS_NOTE_ON = 4'h9;
    localparam logic [7:0] CC_CH0         = {STATUS_CC, 4'h0};
    localparam logic [6:0] CC_UNUSED      = 7'd60;
    localparam int         PHASE_EVENTS   = 55;

    typedef struct {
        logic [7:0] status;
        logic [6:0] number;
        logic [6:0] value;
        logic       complete;
        bit         drain;
    } midi_msg_t;

    typedef struct packed {
        event_kind_t kind;
        logic        render;
        logic        pad_changed;
        logic [3:0]  pad_number;
        logic [6:0]  velocity;
        logic        bank_changed;
        logic [1:0]  pad_bank;
        logic [2:0]  slot_index;
        logic [6:0]  slot_value;
        logic        flag_state;
        logic [1:0]  page_index;
        logic [3:0]  time_division;
    } cc_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         status_byte = '0;
    logic [6:0]         data_one = '0;
    logic [6:0]         data_two = '0;
    logic               message_complete = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] page_count = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [3:0]         event_kind;
    logic               render;
    logic               pad_changed;
    logic [3:0]         pad_number;
    logic [6:0]         velocity;
    logic               bank_changed;
    logic [1:0]         pad_bank;
    logic [2:0]         slot_index;
    logic [6:0]         slot_value;
    logic               flag_state;
    logic [1:0]         page_index;
    logic [3:0]         time_division;

    midi_msg_t midi_queue[$];
    midi_msg_t held_msg;
    cc_event_t events_due[$];
    int        events_predicted = 0;
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        launch;

    logic [6:0] slot_level [DEPTH];
    logic       slot_flag [DEPTH];
    logic [1:0] page_now;
    logic [2:0] slot_now;
    logic [1:0] bank_now;
    logic [3:0] division_now;
    logic       division_hold;
    logic       shift_hold;
    int         pages_in_use;

    control_surface_cc_reducer_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .status_byte      (status_byte),
        .data_one         (data_one),
        .data_two         (data_two),
        .message_complete (message_complete),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .page_count       (page_count),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .event_kind       (event_kind),
        .render           (render),
        .pad_changed      (pad_changed),
        .pad_number       (pad_number),
        .velocity         (velocity),
        .bank_changed     (bank_changed),
        .pad_bank         (pad_bank),
        .slot_index       (slot_index),
        .slot_value       (slot_value),
        .flag_state       (flag_state),
        .page_index       (page_index),
        .time_division    (time_division)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("control_surface_cc_reducer_core verification failed");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] cell_of(logic [2:0] slot);
        return {page_now, slot};
    endfunction

    function automatic logic [6:0] nudge(logic [6:0] old, logic [6:0] delta);
        int level;
        level = (delta == VALUE_MAX) ? int'(old) - 1 : int'(old) + int'(delta);
        if (level < 0)
        begin
            level = 0;
        end
        if (level > int'(VALUE_MAX))
        begin
            level = int'(VALUE_MAX);
        end
        return 7'(level);
    endfunction

    function automatic cc_event_t snapshot(event_kind_t kind, logic [3:0] pad,
                                           logic [6:0] vel, logic flag);
        cc_event_t ev;
        ev.kind          = kind;
        ev.render        = (kind != EV_DIV_HELD) && (kind != EV_SHIFT_HELD);
        ev.pad_changed   = (kind == EV_PAD);
        ev.pad_number    = pad;
        ev.velocity      = vel;
        ev.bank_changed  = (kind == EV_BANK);
        ev.pad_bank      = bank_now;
        ev.slot_index    = slot_now;
        ev.slot_value    = slot_level[cell_of(slot_now)];
        ev.flag_state    = flag;
        ev.page_index    = page_now;
        ev.time_division = division_now;
        return ev;
    endfunction

    task automatic reset_surface_model();
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_level[i] = VALUE_RESET;
            slot_flag[i]  = 1'b0;
        end
        page_now      = '0;
        slot_now      = '0;
        bank_now      = '0;
        division_now  = DIV_RESET;
        division_hold = 1'b0;
        shift_hold    = 1'b0;
        pages_in_use  = PAGES;
    endtask

    task automatic apply_page_count(input logic [COUNT_W-1:0] value);
        pages_in_use = (value < 1) ? 1 : ((value > PAGES) ? PAGES : int'(value));
        if (int'(page_now) >= pages_in_use)
        begin
            page_now = 2'(pages_in_use - 1);
        end
    endtask

    task automatic record_event(input cc_event_t ev);
        events_due.push_back(ev);
        events_predicted++;
    endtask

    task automatic predict_message(input midi_msg_t m);
        bit                pressed;
        logic [ADDR_W-1:0] c;
        pressed = (m.value == VALUE_PRESSED);
        if (m.complete && m.status[7:4] == STATUS_CC)
        begin
            if (m.number >= CC_PAD_FIRST && m.number <= CC_PAD_LAST)
            begin
                record_event(snapshot(EV_PAD, 4'(m.number), m.value, 1'b0));
            end
            else if (m.number >= CC_ENC_FIRST && m.number <= CC_ENC_LAST)
            begin
                slot_now = 3'(m.number - CC_ENC_FIRST);
                c = cell_of(slot_now);
                slot_level[c] = nudge(slot_level[c], m.value);
                record_event(snapshot(EV_ENCODER, '0, '0, 1'b0));
            end
            else if (m.number >= CC_SW_FIRST && m.number <= CC_SW_LAST)
            begin
                if (pressed)
                begin
                    slot_now = 3'(m.number - CC_SW_FIRST);
                    if (division_hold)
                    begin
                        division_now = 4'(slot_now) + 4'd1;
                        record_event(snapshot(EV_DIV_PICK, '0, '0, 1'b0));
                    end
                    else
                    begin
                        c = cell_of(slot_now);
                        slot_flag[c] = ~slot_flag[c];
                        record_event(snapshot(EV_SWITCH, '0, '0, slot_flag[c]));
                    end
                end
            end
            else if (m.number == CC_DIAL)
            begin
                c = cell_of(slot_now);
                slot_level[c] = nudge(slot_level[c], m.value);
                record_event(snapshot(EV_DIAL, '0, '0, 1'b0));
            end
            else if (m.number >= CC_MODE_FIRST && m.number <= CC_MODE_LAST && pressed)
            begin
                if (int'(m.number - CC_MODE_FIRST) < pages_in_use)
                begin
                    page_now = 2'(m.number - CC_MODE_FIRST);
                    record_event(snapshot(EV_MODE_PAGE, '0, '0, 1'b0));
                end
            end
            else if (m.number == CC_LEFT && pressed)
            begin
                page_now = 2'((int'(page_now) + pages_in_use - 1) % pages_in_use);
                record_event(snapshot(EV_LEFT, '0, '0, 1'b0));
            end
            else if (m.number == CC_RIGHT && pressed)
            begin
                page_now = 2'((int'(page_now) + 1) % pages_in_use);
                record_event(snapshot(EV_RIGHT, '0, '0, 1'b0));
            end
            else if (m.number >= CC_BANK_FIRST && m.number <= CC_BANK_LAST && pressed
                     && shift_hold)
            begin
                bank_now = 2'(m.number - CC_BANK_FIRST);
                record_event(snapshot(EV_BANK, '0, '0, 1'b0));
            end
            else if (m.number == CC_DIV_HOLD)
            begin
                division_hold = pressed;
                record_event(snapshot(EV_DIV_HELD, '0, '0, division_hold));
            end
            else if (m.number == CC_SHIFT)
            begin
                shift_hold = pressed;
                record_event(snapshot(EV_SHIFT_HELD, '0, '0, shift_hold));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_message(held_msg);
            end
            if (!in_valid || in_ready)
            begin
                launch = 1'b0;
                if (midi_queue.size() > 0)
                begin
                    if (midi_queue[0].drain)
                    begin
                        if (events_due.size() == 0)
                        begin
                            void'(midi_queue.pop_front());
                        end
                    end
                    else if ($urandom_range(0, 99) >= send_idle_pct)
                    begin
                        held_msg = midi_queue.pop_front();
                        launch = 1'b1;
                    end
                end
                in_valid <= launch;
                if (launch)
                begin
                    status_byte      <= held_msg.status;
                    data_one         <= held_msg.number;
                    data_two         <= held_msg.value;
                    message_complete <= held_msg.complete;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch, %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                report_mismatch("result transfer with no event outstanding");
            end
            else
            begin
                cc_event_t want;
                want = events_due.pop_front();
                check_field("event_kind", 8'(event_kind), 8'(want.kind));
                check_field("render", 8'(render), 8'(want.render));
                check_field("pad_changed", 8'(pad_changed), 8'(want.pad_changed));
                check_field("pad_number", 8'(pad_number), 8'(want.pad_number));
                check_field("velocity", 8'(velocity), 8'(want.velocity));
                check_field("bank_changed", 8'(bank_changed), 8'(want.bank_changed));
                check_field("pad_bank", 8'(pad_bank), 8'(want.pad_bank));
                check_field("slot_index", 8'(slot_index), 8'(want.slot_index));
                check_field("slot_value", 8'(slot_value), 8'(want.slot_value));
                check_field("flag_state", 8'(flag_state), 8'(want.flag_state));
                check_field("page_index", 8'(page_index), 8'(want.page_index));
                check_field("time_division", 8'(time_division), 8'(want.time_division));
            end
        end
    end

    task automatic push_raw(input logic [7:0] status, input logic [6:0] number,
                            input logic [6:0] value, input logic complete);
        midi_msg_t m;
        m.status   = status;
        m.number   = number;
        m.value    = value;
        m.complete = complete;
        m.drain    = 1'b0;
        midi_queue.push_back(m);
    endtask

    task automatic push_drain();
        midi_msg_t m;
        m.status   = '0;
        m.number   = '0;
        m.value    = '0;
        m.complete = 1'b0;
        m.drain    = 1'b1;
        midi_queue.push_back(m);
    endtask

    // A small share of otherwise well-formed messages is broken on purpose.
    task automatic push_cc(input logic [6:0] number, input logic [6:0] value);
        logic [7:0] status;
        logic       complete;
        int         r;
        status   = {STATUS_CC, 4'($urandom_range(0, 15))};
        complete = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            complete = 1'b0;
        end
        else if (r < 8)
        begin
            status = {STATUS_POLY, 4'($urandom_range(0, 15))};
        end
        push_raw(status, number, value, complete);
    endtask

    function automatic logic [6:0] press_or_not(int pressed_pct);
        if ($urandom_range(0, 99) < pressed_pct)
        begin
            return VALUE_PRESSED;
        end
        return 7'($urandom_range(0, 126));
    endfunction

    task automatic queue_sequence();
        int         pick;
        int         n;
        logic [6:0] number;
        logic [6:0] value;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            push_raw(8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                     7'($urandom_range(0, 127)), ($urandom_range(0, 3) != 0));
        end
        else if (pick < 20)
        begin
            push_cc(CC_SHIFT, VALUE_PRESSED);
            push_cc(CC_BANK_FIRST + 7'($urandom_range(0, 3)), press_or_not(85));
            push_cc(CC_SHIFT, press_or_not(10));
        end
        else if (pick < 28)
        begin
            push_cc(CC_DIV_HOLD, VALUE_PRESSED);
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
            begin
                push_cc(CC_SW_FIRST + 7'($urandom_range(0, 7)), press_or_not(85));
            end
            push_cc(CC_DIV_HOLD, press_or_not(10));
        end
        else if (pick < 36)
        begin
            number = ($urandom_range(0, 3) == 0) ? CC_DIAL
                                                 : CC_ENC_FIRST + 7'($urandom_range(0, 7));
            n = ($urandom_range(0, 5) == 0) ? 70 : $urandom_range(3, 20);
            value = ($urandom_range(0, 1) == 0) ? VALUE_MAX : 7'($urandom_range(1, 126));
            for (int i = 0; i < n; i++)
            begin
                push_cc(number, value);
            end
        end
        else
        begin
            case ($urandom_range(0, 10))
                0: push_cc(CC_PAD_FIRST + 7'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
                1: push_cc(CC_ENC_FIRST + 7'($urandom_range(0, 7)), press_or_not(30));
                2: push_cc(CC_SW_FIRST + 7'($urandom_range(0, 7)), press_or_not(75));
                3: push_cc(CC_DIAL, press_or_not(30));
                4: push_cc(CC_MODE_FIRST + 7'($urandom_range(0, 3)), press_or_not(80));
                5: push_cc(CC_LEFT, press_or_not(80));
                6: push_cc(CC_RIGHT, press_or_not(80));
                7: push_cc(CC_BANK_FIRST + 7'($urandom_range(0, 3)), press_or_not(80));
                8: push_cc(CC_DIV_HOLD, press_or_not(50));
                9: push_cc(CC_SHIFT, press_or_not(50));
                default: push_cc(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
            endcase
        end
    endtask

    task automatic wait_for_quiet();
        do
        begin
            @(negedge clk);
        end
        while (midi_queue.size() != 0 || in_valid || events_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_page_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        page_count <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        apply_page_count(value);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [COUNT_W-1:0] count, input int send_pct,
                                    input int recv_pct);
        int  goal;
        bit  paused;
        wait_for_quiet();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_page_count(count);
        goal   = events_predicted + PHASE_EVENTS;
        paused = 1'b0;
        while (events_predicted < goal)
        begin
            queue_sequence();
            if (!paused && events_predicted >= goal - PHASE_EVENTS / 2)
            begin
                push_drain();
                paused = 1'b1;
            end
            while (midi_queue.size() > 4)
            begin
                @(posedge clk);
            end
        end
    endtask

    initial
    begin
        int waited;
        reset_surface_model();
        send_idle_pct = 11;
        recv_idle_pct = 72;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_page_count(3'd3);
        push_raw(CC_CH0, CC_PAD_FIRST, VALUE_PRESSED, 1'b0);
        push_raw({STATUS_POLY, 4'h3}, CC_PAD_FIRST, VALUE_PRESSED, 1'b1);
        push_raw({STATUS_NOTE_ON, 4'h0}, CC_ENC_FIRST, 7'd1, 1'b1);
        push_raw(8'hFF, 7'h7F, 7'h7F, 1'b1);
        push_raw({STATUS_CC, 4'hF}, CC_PAD_FIRST, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_PAD_LAST, 7'd0, 1'b1);
        push_raw(CC_CH0, CC_ENC_FIRST, VALUE_MAX, 1'b1);
        push_raw(CC_CH0, CC_ENC_LAST, 7'd126, 1'b1);
        push_raw(CC_CH0, CC_SW_FIRST, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_SW_LAST, 7'd126, 1'b1);
        push_raw(CC_CH0, CC_DIV_HOLD, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_SW_FIRST + 7'd3, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_DIV_HOLD, 7'd0, 1'b1);
        push_raw(CC_CH0, CC_DIAL, 7'd5, 1'b1);
        push_raw(CC_CH0, CC_MODE_LAST, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_MODE_FIRST + 7'd2, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_MODE_FIRST, 7'd0, 1'b1);
        push_raw(CC_CH0, CC_RIGHT, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_LEFT, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_BANK_FIRST, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_SHIFT, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_BANK_LAST, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, CC_BANK_FIRST + 7'd1, 7'd0, 1'b1);
        push_raw(CC_CH0, CC_SHIFT, 7'd1, 1'b1);
        push_raw(CC_CH0, CC_UNUSED, VALUE_PRESSED, 1'b1);
        push_raw(CC_CH0, 7'd127, 7'd127, 1'b1);
        push_raw(8'h00, 7'd0, 7'd0, 1'b1);

        run_random_phase(3'd1, 11, 72);
        run_random_phase(3'd0, 11, 72);
        run_random_phase(3'd7, 72, 11);
        run_random_phase(3'd2, 72, 11);
        run_random_phase(3'd4, 0, 0);
        run_random_phase(3'd5, 0, 0);

        waited = 0;
        while ((midi_queue.size() != 0 || in_valid || events_due.size() != 0)
               && waited < 20000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (5) @(posedge clk);
        if (events_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d events never delivered", events_due.size()));
        end

        if (mismatches == 0)
        begin
            $display("control_surface_cc_reducer_core verification clean");
        end
        else
        begin
            $display("control_surface_cc_reducer_core verification failed");
        end
        $finish;
    end

endmodule
